/* hdl/eu_dst_rule_from_utc_seconds_macros.svh */
// assertion macros shared by the summer time block
`ifndef EU_DST_RULE_FROM_UTC_SECONDS_MACROS_SVH
`define EU_DST_RULE_FROM_UTC_SECONDS_MACROS_SVH
`ifndef ASSERT_OFF
// checked while out of reset
`define EUDST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define EUDST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define EUDST_ASSERT(lbl, prop, msg)
`define EUDST_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hdl/eudst_pkg.sv */
// types, constants and helper functions of the summer time block
`default_nettype none
package eudst_pkg;

  // field widths
  localparam int unsigned UTC_W      = 32;
  localparam int unsigned OFFSET_W   = 17;
  localparam int unsigned SHIFT_W    = 13;
  localparam int unsigned YEAR_W     = 12;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned DAYS_W     = 16;
  localparam int unsigned DOY_W      = 9;
  localparam int unsigned CYC_W      = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned PIPE_DEPTH = 8;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZONE_OFFSET = 2'd0,
    CFG_DST_SHIFT   = 2'd1
  } cfg_idx_e;

  localparam logic [OFFSET_W-1:0] ZONE_OFFSET_RST = 17'd3600;
  localparam logic [SHIFT_W-1:0]  DST_SHIFT_RST   = 13'd3600;

  // months
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  // march-based month index of january
  localparam logic [MONTH_W-1:0] MP_JAN    = 4'd10;
  localparam logic [MONTH_W-1:0] MP_LAST   = 4'd11;

  // utc / 3600 computed as (utc >> 4) / 225 by reciprocal
  localparam int unsigned         HOURS_SHIFT = 36;
  localparam logic [28:0]         HOURS_RECIP = 29'd305419897;
  // (hours >> 3) / 3 by reciprocal
  localparam int unsigned         DIV3_SHIFT  = 20;
  localparam logic [18:0]         DIV3_RECIP  = 19'd349526;
  // day count / 1461 by reciprocal
  localparam int unsigned         CYC_SHIFT   = 27;
  localparam logic [16:0]         CYC_RECIP   = 17'd91868;

  localparam logic [10:0]         CYCLE_DAYS  = 11'd1461;
  localparam logic [10:0]         YEAR1_DAYS  = 11'd365;
  localparam logic [10:0]         YEAR2_DAYS  = 11'd730;
  localparam logic [10:0]         YEAR3_DAYS  = 11'd1095;
  // days from 1968-03-01 to 1970-01-01
  localparam logic [DAYS_W-1:0]   EPOCH_BIAS  = 16'd671;
  // day number of 2100-03-01, where the missing leap day is skipped
  localparam logic [DAYS_W-1:0]   SKIP_LEAP_DAY = 16'd47541;
  // four-year cycle holding february 2100
  localparam logic [CYC_W-1:0]    CENTURY_CYC = 6'd32;
  localparam logic [YEAR_W-1:0]   BASE_YEAR   = 12'd1968;
  // 1970-01-01 was a thursday, sunday is 0
  localparam logic [2:0]          WEEKDAY_BIAS = 3'd4;

  localparam logic [DAY_W-1:0]    LAST_SUNDAY_MIN = 5'd22;
  localparam logic [HOUR_W-1:0]   SWITCH_HOUR     = 5'd1;
  localparam logic [HOUR_W-1:0]   MAX_HOUR        = 5'd23;

  typedef struct packed {
    logic [UTC_W-1:0]  utc;
    logic [DAYS_W-1:0] days;
    logic [HOUR_W-1:0] hour;
  } tsplit_t;

  typedef struct packed {
    tsplit_t            t;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [DAY_W-1:0]   mlen;
  } date_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] zone_offset;
    logic [SHIFT_W-1:0]  dst_shift;
  } cfg_t;

  // first day-of-year of each march-based month
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] mp);
    logic [DOY_W-1:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR,
      MONTH_JUN,
      MONTH_SEP,
      MONTH_NOV: len = 5'd30;
      default:   len = 5'd31;
    endcase
    return len;
  endfunction

  // remainder by 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [DAYS_W-1:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [3:0] r;
    s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) + 6'(v[15]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
    return r[2:0];
  endfunction

endpackage
`default_nettype wire

/* hdl/eudst_cfg_regs.sv */
// configuration registers: zone offset and summer time shift
`default_nettype none
module eudst_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [eudst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [eudst_pkg::OFFSET_W-1:0]    cfg_data_i,
  output eudst_pkg::cfg_t                   cfg_o
);
  import eudst_pkg::*;

  cfg_t cfg_d, cfg_q;

  // writes are taken on any cycle
  assign cfg_ready_o = 1'b1;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ZONE_OFFSET: cfg_d.zone_offset = cfg_data_i;
        CFG_DST_SHIFT:   cfg_d.dst_shift   = cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zone_offset <= ZONE_OFFSET_RST;
      cfg_q.dst_shift   <= DST_SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* hdl/eudst_time_split.sv */
// two stages: seconds to hours, hours to day count and hour of day
`default_nettype none
module eudst_time_split (
  input  logic                         clk_i,
  input  logic [eudst_pkg::UTC_W-1:0]  utc_i,
  output eudst_pkg::tsplit_t           split_o
);
  import eudst_pkg::*;

  logic [56:0]      hour_prod;
  logic [20:0]      hours_d, hours_q;
  logic [UTC_W-1:0] utc_q;
  logic [17:0]      hours8;
  logic [37:0]      div3_prod;
  logic [DAYS_W-1:0] days;
  logic [17:0]      rem3;
  tsplit_t          split_d, split_q;

  // hours since epoch
  assign hour_prod = 57'(utc_i[UTC_W-1:4]) * 57'(HOURS_RECIP);
  assign hours_d   = hour_prod[HOURS_SHIFT+20:HOURS_SHIFT];

  always_ff @(posedge clk_i) begin
    hours_q <= hours_d;
    utc_q   <= utc_i;
  end

  // days = hours / 24, hour = hours mod 24
  assign hours8    = hours_q[20:3];
  assign div3_prod = 38'(hours8) * 38'(DIV3_RECIP);
  assign days      = div3_prod[DIV3_SHIFT+DAYS_W-1:DIV3_SHIFT];
  assign rem3      = hours8 - 18'(days) - 18'({days, 1'b0});

  always_comb begin
    split_d.utc  = utc_q;
    split_d.days = days;
    split_d.hour = {rem3[1:0], hours_q[2:0]};
  end

  always_ff @(posedge clk_i) begin
    split_q <= split_d;
  end

  assign split_o = split_q;

endmodule
`default_nettype wire

/* hdl/eudst_civil_date.sv */
// three stages: day count to civil year, month, day and month length
`default_nettype none
module eudst_civil_date (
  input  logic                clk_i,
  input  eudst_pkg::tsplit_t  split_i,
  output eudst_pkg::date_t    date_o
);
  import eudst_pkg::*;

  logic [DAYS_W-1:0] n_d, n_q;
  logic [32:0]       cyc_prod;
  logic [CYC_W-1:0]  cyc_d, cyc_q;
  tsplit_t           t3_q, t4_q;

  logic [DAYS_W-1:0] cyc_days;
  logic [10:0]       rem_days;
  logic [1:0]        yoc;
  logic [DOY_W-1:0]  doy_d, doy_q;
  logic              leap_d, leap_q;
  logic [YEAR_W-1:0] year_m_d, year_m_q;

  logic [MONTH_W-1:0] mp;
  date_t              date_d, date_q;

  // days from 1968-03-01, with february 29 2100 skipped
  always_comb begin
    if (split_i.days >= SKIP_LEAP_DAY) begin
      n_d = split_i.days + EPOCH_BIAS + 16'd1;
    end else begin
      n_d = split_i.days + EPOCH_BIAS;
    end
  end

  // four-year cycle number
  assign cyc_prod = 33'(n_d) * 33'(CYC_RECIP);
  assign cyc_d    = cyc_prod[CYC_SHIFT+CYC_W-1:CYC_SHIFT];

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    cyc_q <= cyc_d;
    t3_q  <= split_i;
  end

  // year within cycle and day of march-based year
  assign cyc_days = 16'(cyc_q) * 16'(CYCLE_DAYS);
  assign rem_days = 11'(n_q - cyc_days);
  assign yoc      = 2'(rem_days >= YEAR1_DAYS) + 2'(rem_days >= YEAR2_DAYS)
                  + 2'(rem_days >= YEAR3_DAYS);
  assign doy_d    = 9'(rem_days - 11'(yoc) * YEAR1_DAYS);
  assign leap_d   = (yoc == 2'd3) && (cyc_q != CENTURY_CYC);
  assign year_m_d = BASE_YEAR + 12'({cyc_q, 2'b00}) + 12'(yoc);

  always_ff @(posedge clk_i) begin
    doy_q    <= doy_d;
    leap_q   <= leap_d;
    year_m_q <= year_m_d;
    t4_q     <= t3_q;
  end

  // month from parallel compares against month starts
  always_comb begin
    mp = '0;
    for (int k = 1; k <= 11; k++) begin
      if (doy_q >= month_start(4'(k))) begin
        mp = mp + 4'd1;
      end
    end
  end

  always_comb begin
    date_d.t   = t4_q;
    date_d.day = 5'(doy_q - month_start(mp) + 9'd1);
    if (mp >= MP_JAN) begin
      date_d.month = mp - (MP_JAN - 4'd1);
      date_d.year  = year_m_q + 12'd1;
    end else begin
      date_d.month = mp + MONTH_MAR;
      date_d.year  = year_m_q;
    end
    date_d.mlen = month_length(date_d.month, leap_q);
  end

  always_ff @(posedge clk_i) begin
    date_q <= date_d;
  end

  assign date_o = date_q;

endmodule
`default_nettype wire

/* hdl/eudst_rule.sv */
// two stages: last sunday and summer time decision, then local seconds
`default_nettype none
module eudst_rule (
  input  logic                           clk_i,
  input  eudst_pkg::date_t               date_i,
  input  eudst_pkg::cfg_t                cfg_i,
  output logic                           dst_active_o,
  output logic [eudst_pkg::UTC_W-1:0]    local_seconds_o,
  output logic [eudst_pkg::YEAR_W-1:0]   utc_year_o,
  output logic [eudst_pkg::MONTH_W-1:0]  utc_month_o,
  output logic [eudst_pkg::DAY_W-1:0]    utc_day_o,
  output logic [eudst_pkg::HOUR_W-1:0]   utc_hour_o,
  output logic [eudst_pkg::DAY_W-1:0]    switch_sunday_o
);
  import eudst_pkg::*;

  logic [DAY_W-1:0]  to_end;
  logic [2:0]        wday_last;
  logic [DAY_W-1:0]  sun_d, sun_q;
  logic              dst_d, dst_q;
  date_t             date_q;

  logic [UTC_W-1:0]  offset_ext;
  logic [UTC_W-1:0]  shift_add;
  logic [UTC_W-1:0]  local_d;

  // weekday of the month's last day, then its last sunday
  assign to_end    = date_i.mlen - date_i.day;
  assign wday_last = mod7(date_i.t.days + 16'(to_end) + 16'(WEEKDAY_BIAS));
  assign sun_d     = date_i.mlen - 5'(wday_last);

  // european rule, switching at 01:00 utc
  always_comb begin
    priority if (date_i.month < MONTH_MAR || date_i.month > MONTH_OCT) begin
      dst_d = 1'b0;
    end else if (date_i.month == MONTH_MAR) begin
      dst_d = (date_i.day > sun_d) ||
              (date_i.day == sun_d && date_i.t.hour >= SWITCH_HOUR);
    end else if (date_i.month == MONTH_OCT) begin
      dst_d = (date_i.day < sun_d) ||
              (date_i.day == sun_d && date_i.t.hour < SWITCH_HOUR);
    end else begin
      dst_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    date_q <= date_i;
    sun_q  <= sun_d;
    dst_q  <= dst_d;
  end

  // local time, wrapping modulo 2^32
  assign offset_ext = {{(UTC_W-OFFSET_W){cfg_i.zone_offset[OFFSET_W-1]}}, cfg_i.zone_offset};
  assign shift_add  = dst_q ? UTC_W'(cfg_i.dst_shift) : '0;
  assign local_d    = date_q.t.utc + offset_ext + shift_add;

  always_ff @(posedge clk_i) begin
    dst_active_o    <= dst_q;
    local_seconds_o <= local_d;
    utc_year_o      <= date_q.year;
    utc_month_o     <= date_q.month;
    utc_day_o       <= date_q.day;
    utc_hour_o      <= date_q.t.hour;
    switch_sunday_o <= sun_q;
  end

endmodule
`default_nettype wire

/* hdl/eu_dst_rule_from_utc_seconds.sv */
// top level: european summer time decision from utc seconds
//
// Usage:
//   Input channel: drive utc_seconds_i and raise start; the item is taken at
//   the clock edge where start is high and busy is low. busy stays low, so
//   one item may be started on every cycle.
//   Result channel: done_o is high for exactly one cycle per item, with the
//   date fields, the last sunday of the month, dst_active_o and
//   local_seconds_o valid in that cycle. The receiver cannot hold results
//   off; results leave in the order items were taken.
//   Pipeline: the path from the accepting edge is an input register
//   followed by seven register stages (hours, day count, four-year cycle,
//   day of year, calendar date, weekday rule, local sum). Throughput is one
//   item per cycle.
//   Configuration: cfg_index_i selects zone offset (0) or summer shift (1),
//   written when cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always
//   high. Write only with no item in flight.
//   Reset: rst_ni clears the valid pipeline (no done_o pulses) and restores
//   zone offset and shift to 3600 seconds each.
`default_nettype none
`include "eu_dst_rule_from_utc_seconds_macros.svh"
module eu_dst_rule_from_utc_seconds (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [eudst_pkg::UTC_W-1:0]       utc_seconds_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [eudst_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [eudst_pkg::OFFSET_W-1:0]    cfg_data_i,
  output logic                              done_o,
  output logic                              dst_active_o,
  output logic [eudst_pkg::UTC_W-1:0]       local_seconds_o,
  output logic [eudst_pkg::YEAR_W-1:0]      utc_year_o,
  output logic [eudst_pkg::MONTH_W-1:0]     utc_month_o,
  output logic [eudst_pkg::DAY_W-1:0]       utc_day_o,
  output logic [eudst_pkg::HOUR_W-1:0]      utc_hour_o,
  output logic [eudst_pkg::DAY_W-1:0]       switch_sunday_o
);
  import eudst_pkg::*;

  logic                  accept;
  logic [PIPE_DEPTH-1:0] valid_d, valid_q;
  logic [UTC_W-1:0]      utc_q;
  cfg_t                  cfg;
  tsplit_t               split;
  date_t                 date;

  // pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // item valid flags follow the payload down the stages
  assign valid_d = {valid_q[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign done_o = valid_q[PIPE_DEPTH-1];

  // input register
  always_ff @(posedge clk_i) begin
    utc_q <= utc_seconds_i;
  end

  eudst_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  eudst_time_split u_split (
    .clk_i   (clk_i),
    .utc_i   (utc_q),
    .split_o (split)
  );

  eudst_civil_date u_date (
    .clk_i   (clk_i),
    .split_i (split),
    .date_o  (date)
  );

  eudst_rule u_rule (
    .clk_i           (clk_i),
    .date_i          (date),
    .cfg_i           (cfg),
    .dst_active_o    (dst_active_o),
    .local_seconds_o (local_seconds_o),
    .utc_year_o      (utc_year_o),
    .utc_month_o     (utc_month_o),
    .utc_day_o       (utc_day_o),
    .utc_hour_o      (utc_hour_o),
    .switch_sunday_o (switch_sunday_o)
  );

  // every result traces back to an earlier start
  `EUDST_ASSERT(a_done_has_start, done_o |-> $past(start, PIPE_DEPTH), "result without item")
  // summer time only from march to october
  `EUDST_ASSERT(a_dst_months, done_o && dst_active_o |-> (utc_month_o >= MONTH_MAR && utc_month_o <= MONTH_OCT), "dst outside season")
  // decoded fields stay in their calendar ranges
  `EUDST_ASSERT(a_field_ranges, done_o |-> (switch_sunday_o >= LAST_SUNDAY_MIN && utc_hour_o <= MAX_HOUR && utc_day_o != '0), "date field out of range")
  // reset leaves no result pending
  `EUDST_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !done_o, "result after reset")

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// self-checking testbench for the european summer time block
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned SECS_DAY         = 86400;
  localparam int unsigned SECS_HOUR        = 3600;
  localparam int unsigned EPOCH_YEAR       = 1970;
  localparam int unsigned LAST_SAFE_YEAR   = 2105;
  localparam int unsigned MARCH            = 3;
  localparam int unsigned OCTOBER          = 10;
  localparam int unsigned SWITCH_HOUR_UTC  = 1;
  // 1970-01-01 was a thursday, sunday counts as 0
  localparam int unsigned EPOCH_WEEKDAY    = 4;
  localparam int          OFFSET_LOW       = -43200;
  localparam int          OFFSET_HIGH      = 50400;
  localparam int unsigned SHIFT_HIGH       = 7200;
  localparam int unsigned RANDOM_PER_PHASE = 195;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned STALL_LIMIT      = 2000;
  // indexes that map to no register
  localparam logic [eudst_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [eudst_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    logic                               dst_on;
    logic [eudst_pkg::UTC_W-1:0]        local_secs;
    logic [eudst_pkg::YEAR_W-1:0]       year;
    logic [eudst_pkg::MONTH_W-1:0]      month;
    logic [eudst_pkg::DAY_W-1:0]        day;
    logic [eudst_pkg::HOUR_W-1:0]       hour;
    logic [eudst_pkg::DAY_W-1:0]        sunday;
  } stamp_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [eudst_pkg::UTC_W-1:0]          utc_seconds_i = '0;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [eudst_pkg::CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [eudst_pkg::OFFSET_W-1:0]       cfg_data_i = '0;
  logic                                 done_o;
  logic                                 dst_active_o;
  logic [eudst_pkg::UTC_W-1:0]          local_seconds_o;
  logic [eudst_pkg::YEAR_W-1:0]         utc_year_o;
  logic [eudst_pkg::MONTH_W-1:0]        utc_month_o;
  logic [eudst_pkg::DAY_W-1:0]          utc_day_o;
  logic [eudst_pkg::HOUR_W-1:0]         utc_hour_o;
  logic [eudst_pkg::DAY_W-1:0]          switch_sunday_o;

  // predictor copy of the two registers
  logic [eudst_pkg::OFFSET_W-1:0]       zone_offset_q = eudst_pkg::ZONE_OFFSET_RST;
  logic [eudst_pkg::SHIFT_W-1:0]        dst_shift_q   = eudst_pkg::DST_SHIFT_RST;

  logic [eudst_pkg::UTC_W-1:0]          pending_times[$];
  stamp_t                               due_conversions[$];
  bit                                   item_taken = 1'b0;
  bit                                   cfg_taken = 1'b0;
  int unsigned                          idle_pct = 0;
  int unsigned                          gap_left = 0;
  int unsigned                          n_issued = 0;
  int unsigned                          n_taken = 0;
  int unsigned                          n_checked = 0;
  int unsigned                          n_summer = 0;
  int unsigned                          n_settings = 1;
  int unsigned                          n_errors = 0;
  int unsigned                          stall_cycles = 0;

  eu_dst_rule_from_utc_seconds dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .utc_seconds_i   (utc_seconds_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .dst_active_o    (dst_active_o),
    .local_seconds_o (local_seconds_o),
    .utc_year_o      (utc_year_o),
    .utc_month_o     (utc_month_o),
    .utc_day_o       (utc_day_o),
    .utc_hour_o      (utc_hour_o),
    .switch_sunday_o (switch_sunday_o)
  );

  // calendar helpers
  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      2:             len = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  // days since the epoch of a calendar date
  function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                             input int unsigned d);
    int unsigned n;
    n = d - 1;
    for (int unsigned yy = EPOCH_YEAR; yy < y; yy++) n += 365 + leap_year(yy);
    for (int unsigned mm = 1; mm < m; mm++) n += month_days(y, mm);
    return n;
  endfunction

  function automatic int unsigned sunday_of(input int unsigned y, input int unsigned m);
    int unsigned len;
    len = month_days(y, m);
    return len - ((day_number(y, m, len) + EPOCH_WEEKDAY) % 7);
  endfunction

  // utc second at which the clocks change in march or october
  function automatic longint switch_utc(input int unsigned y, input int unsigned m);
    return longint'(day_number(y, m, sunday_of(y, m))) * SECS_DAY
           + SWITCH_HOUR_UTC * SECS_HOUR;
  endfunction

  // expected conversion of one timestamp under the given registers
  function automatic stamp_t local_time_of(input logic [eudst_pkg::UTC_W-1:0] utc,
                                           input logic [eudst_pkg::OFFSET_W-1:0] off,
                                           input logic [eudst_pkg::SHIFT_W-1:0] shift);
    int unsigned days, rem, y, m, len, sun, hr, d;
    bit on;
    stamp_t r;
    days = utc / SECS_DAY;
    hr   = (utc % SECS_DAY) / SECS_HOUR;
    y    = EPOCH_YEAR;
    rem  = days;
    while (rem >= 365 + leap_year(y)) begin
      rem -= 365 + leap_year(y);
      y++;
    end
    m = 1;
    while (rem >= month_days(y, m)) begin
      rem -= month_days(y, m);
      m++;
    end
    d   = rem + 1;
    len = month_days(y, m);
    // weekday of the month's last day, counted from its first day
    sun = len - ((days - rem + len - 1 + EPOCH_WEEKDAY) % 7);
    if (m < MARCH || m > OCTOBER) on = 1'b0;
    else if (m > MARCH && m < OCTOBER) on = 1'b1;
    else if (m == MARCH) on = (d > sun) || (d == sun && hr >= SWITCH_HOUR_UTC);
    else on = (d < sun) || (d == sun && hr < SWITCH_HOUR_UTC);
    r.dst_on     = on;
    r.local_secs = utc + {{(eudst_pkg::UTC_W-eudst_pkg::OFFSET_W){off[eudst_pkg::OFFSET_W-1]}}, off}
                   + (on ? {{(eudst_pkg::UTC_W-eudst_pkg::SHIFT_W){1'b0}}, shift} : '0);
    r.year       = y[eudst_pkg::YEAR_W-1:0];
    r.month      = m[eudst_pkg::MONTH_W-1:0];
    r.day        = d[eudst_pkg::DAY_W-1:0];
    r.hour       = hr[eudst_pkg::HOUR_W-1:0];
    r.sunday     = sun[eudst_pkg::DAY_W-1:0];
    return r;
  endfunction

  // random timestamp, mostly close to a clock change
  function automatic logic [eudst_pkg::UTC_W-1:0] random_instant();
    int unsigned pick, y, m;
    longint t;
    pick = $urandom_range(99);
    y    = $urandom_range(LAST_SAFE_YEAR, EPOCH_YEAR);
    if (pick < 60) begin
      m = $urandom_range(1) ? MARCH : OCTOBER;
      t = switch_utc(y, m);
      if ($urandom_range(1)) t += longint'($urandom_range(4 * SECS_HOUR)) - 2 * SECS_HOUR;
      else t += longint'($urandom_range(16 * SECS_DAY)) - 8 * SECS_DAY;
    end else if (pick < 80) begin
      // around the start of any month
      m = $urandom_range(12, 1);
      t = longint'(day_number(y, m, 1)) * SECS_DAY
          + longint'($urandom_range(4 * SECS_HOUR)) - 2 * SECS_HOUR;
    end else if (pick < 86) begin
      // near either end of the counter range
      if ($urandom_range(1)) t = longint'($urandom_range(3 * SECS_DAY));
      else t = 64'hFFFF_FFFF - longint'($urandom_range(3 * SECS_DAY));
    end else begin
      t = longint'($urandom);
    end
    return t[eudst_pkg::UTC_W-1:0];
  endfunction

  task automatic queue_time(input longint t);
    pending_times.push_back(t[eudst_pkg::UTC_W-1:0]);
    n_issued++;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // register write while the pipeline is empty
  task automatic write_register(input logic [eudst_pkg::CFG_IDX_W-1:0] idx,
                                input logic [eudst_pkg::OFFSET_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= eudst_pkg::OFFSET_W'($urandom);
  endtask

  // wait until every issued item has come back, then let the pipeline settle
  task automatic drain();
    while (n_taken != n_issued || due_conversions.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic random_phase(input int unsigned pct);
    idle_pct = pct;
    repeat (RANDOM_PER_PHASE) queue_time(random_instant());
    drain();
  endtask

  task automatic set_registers(input logic [eudst_pkg::OFFSET_W-1:0] off,
                               input logic [eudst_pkg::OFFSET_W-1:0] shift);
    write_register(eudst_pkg::CFG_ZONE_OFFSET, off);
    write_register(eudst_pkg::CFG_DST_SHIFT, shift);
    n_settings++;
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // driver: one item per accepted start, with random idle bursts
  always @(negedge clk_i) begin
    logic                        nxt_start;
    logic [eudst_pkg::UTC_W-1:0] nxt_utc;
    nxt_start = start;
    nxt_utc   = utc_seconds_i;
    if (!rst_ni) begin
      nxt_start = 1'b0;
    end else if (start && !item_taken) begin
      // hold the item until the block takes it
    end else if (gap_left != 0) begin
      gap_left--;
      nxt_start = 1'b0;
    end else if (pending_times.size() == 0) begin
      nxt_start = 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap_left  = $urandom_range(13, 1) - 1;
      nxt_start = 1'b0;
      nxt_utc   = $urandom;
    end else begin
      nxt_start = 1'b1;
      nxt_utc   = pending_times.pop_front();
    end
    start         <= nxt_start;
    utc_seconds_i <= nxt_utc;
  end

  // monitor: register writes, accepted items and results
  always @(posedge clk_i) begin
    stamp_t want;
    logic   progress;
    if (!rst_ni) begin
      item_taken = 1'b0;
      cfg_taken  = 1'b0;
    end else begin
      cfg_taken = cfg_valid_i && cfg_ready_o;
      if (cfg_taken) begin
        case (cfg_index_i)
          eudst_pkg::CFG_ZONE_OFFSET: zone_offset_q = cfg_data_i;
          eudst_pkg::CFG_DST_SHIFT:   dst_shift_q   = cfg_data_i[eudst_pkg::SHIFT_W-1:0];
          default: ;
        endcase
      end
      item_taken = start && !busy;
      if (item_taken) begin
        due_conversions.push_back(local_time_of(utc_seconds_i, zone_offset_q, dst_shift_q));
        n_taken++;
      end
      if (done_o) begin
        if (due_conversions.size() == 0) begin
          $error("result arrived with no item outstanding");
          n_errors++;
        end else begin
          want = due_conversions.pop_front();
          check_field("dst_active", want.dst_on, dst_active_o);
          check_field("local_seconds", want.local_secs, local_seconds_o);
          check_field("utc_year", want.year, utc_year_o);
          check_field("utc_month", want.month, utc_month_o);
          check_field("utc_day", want.day, utc_day_o);
          check_field("utc_hour", want.hour, utc_hour_o);
          check_field("switch_sunday", want.sunday, switch_sunday_o);
          n_checked++;
          if (dst_active_o) n_summer++;
        end
      end
      progress = cfg_taken || item_taken || done_o;
      stall_cycles <= (progress === 1'b1) ? 0 : stall_cycles + 1;
    end
  end

  // watchdog on cycles without any handshake
  always @(negedge clk_i) begin
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed items under the reset settings
    idle_pct = 15;
    queue_time(0);
    queue_time(64'hFFFF_FFFF);
    // march switch: just before and exactly at 01:00 utc
    queue_time(switch_utc(2024, MARCH) - 1);
    queue_time(switch_utc(2024, MARCH));
    // october switch: the instant itself is already standard time
    queue_time(switch_utc(2024, OCTOBER) - 1);
    queue_time(switch_utc(2024, OCTOBER));
    queue_time(switch_utc(EPOCH_YEAR, MARCH) - 1);
    queue_time(switch_utc(EPOCH_YEAR, MARCH));
    queue_time(switch_utc(LAST_SAFE_YEAR, OCTOBER) - 1);
    queue_time(switch_utc(LAST_SAFE_YEAR, OCTOBER));
    // leap rules: 2000 has february 29, 2100 does not
    queue_time(longint'(day_number(2000, 2, 29)) * SECS_DAY + 12 * SECS_HOUR);
    queue_time(longint'(day_number(2100, 3, 1)) * SECS_DAY - 1);
    queue_time(longint'(day_number(2100, 3, 1)) * SECS_DAY);
    queue_time(longint'(day_number(2000, 1, 1)) * SECS_DAY - 1);
    queue_time(longint'(day_number(2000, 1, 1)) * SECS_DAY);
    // february with its last sunday on the 29th and on the 22nd
    queue_time(longint'(day_number(2004, 2, 29)) * SECS_DAY);
    queue_time(longint'(day_number(2015, 2, 10)) * SECS_DAY + 5 * SECS_HOUR);
    // month edges of the summer period
    queue_time(longint'(day_number(2023, 3, 1)) * SECS_DAY);
    queue_time(longint'(day_number(2023, 4, 1)) * SECS_DAY);
    queue_time(longint'(day_number(2023, 10, 1)) * SECS_DAY - 1);
    queue_time(longint'(day_number(2023, 11, 1)) * SECS_DAY - 1);
    queue_time(longint'(day_number(2023, 11, 1)) * SECS_DAY);
    drain();
    random_phase(10);

    // range extremes: most western offset with the largest shift
    set_registers(eudst_pkg::OFFSET_W'(OFFSET_LOW), eudst_pkg::OFFSET_W'(SHIFT_HIGH));
    queue_time(0);
    queue_time(64'hFFFF_FFFF);
    random_phase(20);

    // most eastern offset, no shift
    set_registers(eudst_pkg::OFFSET_W'(OFFSET_HIGH), '0);
    queue_time(64'hFFFF_FFFF);
    random_phase(5);

    // out-of-range patterns; the upper data bits of the shift are dropped,
    // and writes to unused indexes leave both registers alone
    set_registers(17'h10000, 17'h1FFFF);
    write_register(CFG_IDX_SPARE_A, eudst_pkg::OFFSET_W'($urandom));
    write_register(CFG_IDX_SPARE_B, eudst_pkg::OFFSET_W'($urandom));
    queue_time(0);
    random_phase(30);

    set_registers(17'h0FFFF, 17'd1);
    random_phase(10);

    // last part runs back to back
    set_registers(eudst_pkg::OFFSET_W'(int'($urandom_range(OFFSET_HIGH - OFFSET_LOW))
                                       + OFFSET_LOW),
                  eudst_pkg::OFFSET_W'($urandom_range(SHIFT_HIGH)));
    random_phase(0);

    $display("converted %0d timestamps, %0d of them in summer time,", n_checked, n_summer);
    $display("under %0d zone offset and shift settings", n_settings);
    if (n_errors == 0 && due_conversions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
